[rtl/core/tilt_angle_deadband_drive_macros.svh]
// Assertion macros shared by the tilt drive checker
`ifndef TILT_ANGLE_DEADBAND_DRIVE_MACROS_SVH
`define TILT_ANGLE_DEADBAND_DRIVE_MACROS_SVH
// Assert that a property holds on every clock edge outside reset
`define TAD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Assert a property that also holds during reset
`define TAD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

[rtl/core/tad_pkg.sv]
// Types, constants and arctangent table of the tilt drive
package tad_pkg;
  localparam int unsigned WorkFrac    = 14;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned AngleW      = 32;
  localparam int unsigned VecW        = 40;
  localparam int unsigned FilterW     = 48;
  localparam logic [29:0] InvGainQ30  = 30'd652032874;
  localparam logic signed [15:0] AngleLimit = 16'sd23040;

  typedef enum logic [1:0] {
    MOTION_HOLD     = 2'd0,
    MOTION_FORWARD  = 2'd1,
    MOTION_BACKWARD = 2'd2
  } motion_e;

  typedef enum logic [1:0] {
    REG_TARGET   = 2'd0,
    REG_DEADBAND = 2'd1,
    REG_GAIN     = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILT_MUL, ST_FILT_ADD, ST_SETUP, ST_VEC1, ST_MAG_MUL, ST_MAG_CHK,
    ST_VEC2, ST_ROUND, ST_DONE
  } back_state_e;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [17:0] err;
    logic [1:0]         motion;
    logic               enable;
  } result_t;

  function automatic logic [AngleW-1:0] atan_lookup(input logic [4:0] idx);
    logic [AngleW-1:0] v;
    case (idx)
      5'd0: v = 32'd2949120;  5'd1: v = 32'd1740967;  5'd2: v = 32'd919879;
      5'd3: v = 32'd466945;   5'd4: v = 32'd234379;   5'd5: v = 32'd117304;
      5'd6: v = 32'd58666;    5'd7: v = 32'd29335;    5'd8: v = 32'd14668;
      5'd9: v = 32'd7334;     5'd10: v = 32'd3667;    5'd11: v = 32'd1833;
      5'd12: v = 32'd917;     5'd13: v = 32'd458;     5'd14: v = 32'd229;
      5'd15: v = 32'd115;     5'd16: v = 32'd57;      5'd17: v = 32'd29;
      5'd18: v = 32'd14;      5'd19: v = 32'd7;       5'd20: v = 32'd4;
      5'd21: v = 32'd2;       5'd22: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

[rtl/core/tad_front.sv]
// Input stage: accepts samples into a two-entry queue for the back end
module tad_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tad_pkg::sample_t in_data_i,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  output tad_pkg::sample_t q_data_o
);
  tad_pkg::sample_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

[rtl/core/tad_back.sv]
// Back end: filters, two CORDIC tilt passes, deadband decision, output register
module tad_back #(
  parameter int unsigned CordicSteps    = 16,
  parameter int unsigned FilterFracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  tad_pkg::sample_t   q_data_i,
  input  logic signed [16:0] target_i,
  input  logic [15:0]        deadband_i,
  input  logic [16:0]        gain_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tad_pkg::result_t   out_data_o
);
  localparam int unsigned FW = tad_pkg::FilterW;
  localparam int unsigned VW = tad_pkg::VecW;
  localparam int unsigned AW = tad_pkg::AngleW;
  localparam int unsigned Steps = (CordicSteps < tad_pkg::AtanEntries) ?
                                  CordicSteps : tad_pkg::AtanEntries;
  localparam logic [4:0] LastStep = 5'(Steps - 1);

  tad_pkg::back_state_e st_q, st_d;
  logic signed [FW-1:0] filt_q [3];
  logic signed [FW-1:0] diff_q;
  logic [1:0]  axis_q;       // filter axis
  logic        pass_q;       // tilt pass: 0 roll, 1 pitch
  logic [4:0]  step_q;
  logic signed [VW-1:0] x_q, y_q;
  logic signed [AW-1:0] z_q;
  logic signed [VW-1:0] num_q;
  logic signed [VW+30:0] mprod_q;
  logic signed [15:0] roll_q, pitch_q;
  logic ena_q;
  logic out_valid_q;
  tad_pkg::result_t out_q;
  tad_pkg::sample_t smp_q;

  logic [16:0] g;
  logic signed [15:0] a_sel;
  logic signed [FW+17:0] prod;
  logic signed [VW-1:0] w [3];
  logic signed [VW-1:0] dx, dy, ua, ub;
  logic signed [AW-1:0] rnd;
  logic signed [15:0] ang;
  logic signed [17:0] err;
  logic [1:0] mot;

  assign g = (gain_i > 17'd65536) ? 17'd65536 : gain_i;
  always_comb begin
    case (axis_q)
      2'd0:    a_sel = smp_q.ax;
      2'd1:    a_sel = smp_q.ay;
      default: a_sel = smp_q.az;
    endcase
  end

  // full-width filter product, one signed 48x18 multiply
  assign prod = diff_q * $signed({1'b0, g});

  for (genvar k = 0; k < 3; k++) begin : g_work
    if (FilterFracBits >= tad_pkg::WorkFrac) begin : g_dn
      assign w[k] = VW'(filt_q[k] >>> (FilterFracBits - tad_pkg::WorkFrac));
    end else begin : g_up
      assign w[k] = VW'(filt_q[k]) <<< (tad_pkg::WorkFrac - FilterFracBits);
    end
  end

  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;
  assign ua = pass_q ? w[1] : w[0];     // magnitude operands per pass
  assign ub = w[2];
  assign rnd = (z_q + AW'(128)) >>> 8;
  always_comb begin
    if (rnd > AW'(signed'(tad_pkg::AngleLimit)))       ang = tad_pkg::AngleLimit;
    else if (rnd < -AW'(signed'(tad_pkg::AngleLimit))) ang = -tad_pkg::AngleLimit;
    else                                               ang = rnd[15:0];
  end
  assign err = 18'(target_i) - 18'(roll_q);
  always_comb begin
    if (err < -$signed({2'b00, deadband_i}))      mot = tad_pkg::MOTION_FORWARD;
    else if (err > $signed({2'b00, deadband_i})) mot = tad_pkg::MOTION_BACKWARD;
    else                                         mot = tad_pkg::MOTION_HOLD;
  end

  always_comb begin
    st_d = st_q;
    q_pop_o = 1'b0;
    case (st_q)
      tad_pkg::ST_IDLE:     if (q_valid_i) begin q_pop_o = 1'b1; st_d = tad_pkg::ST_FILT_MUL; end
      tad_pkg::ST_FILT_MUL: st_d = tad_pkg::ST_FILT_ADD;
      tad_pkg::ST_FILT_ADD: st_d = (axis_q == 2'd2) ? tad_pkg::ST_SETUP : tad_pkg::ST_FILT_MUL;
      tad_pkg::ST_SETUP:    st_d = tad_pkg::ST_VEC1;
      tad_pkg::ST_VEC1:     if (step_q == LastStep) st_d = tad_pkg::ST_MAG_MUL;
      tad_pkg::ST_MAG_MUL:  st_d = tad_pkg::ST_MAG_CHK;
      tad_pkg::ST_MAG_CHK:  st_d = tad_pkg::ST_VEC2;
      tad_pkg::ST_VEC2:     if (step_q == LastStep) st_d = tad_pkg::ST_ROUND;
      tad_pkg::ST_ROUND:    st_d = pass_q ? tad_pkg::ST_DONE : tad_pkg::ST_SETUP;
      tad_pkg::ST_DONE:     if (!out_valid_q || out_ready_i) st_d = tad_pkg::ST_IDLE;
      default:              st_d = tad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tad_pkg::ST_IDLE;
      for (int k = 0; k < 3; k++) filt_q[k] <= '0;
      ena_q <= 1'b0;
      out_valid_q <= 1'b0;
      axis_q <= '0;
      pass_q <= 1'b0;
      step_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == tad_pkg::ST_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        tad_pkg::ST_IDLE: begin
          smp_q <= q_data_i;
          axis_q <= '0;
          pass_q <= 1'b0;
        end
        tad_pkg::ST_FILT_MUL: begin
          diff_q <= (FW'(a_sel) <<< FilterFracBits) - filt_q[axis_q];
        end
        tad_pkg::ST_FILT_ADD: begin
          filt_q[axis_q] <= filt_q[axis_q] + FW'(prod >>> 16);
          axis_q <= axis_q + 2'd1;
        end
        tad_pkg::ST_SETUP: begin
          x_q <= (ua < 0) ? -ua : ua;
          y_q <= (ub < 0) ? -ub : ub;
          z_q <= '0;
          step_q <= '0;
          num_q <= pass_q ? w[0] : w[1];
        end
        tad_pkg::ST_VEC1, tad_pkg::ST_VEC2: begin
          if (y_q < 0) begin
            x_q <= x_q - dx; y_q <= y_q + dy;
            z_q <= z_q - $signed(tad_pkg::atan_lookup(step_q));
          end else begin
            x_q <= x_q + dx; y_q <= y_q - dy;
            z_q <= z_q + $signed(tad_pkg::atan_lookup(step_q));
          end
          step_q <= (step_q == LastStep) ? 5'd0 : step_q + 5'd1;
        end
        tad_pkg::ST_MAG_MUL: begin
          mprod_q <= x_q * $signed({1'b0, tad_pkg::InvGainQ30});
        end
        tad_pkg::ST_MAG_CHK: begin
          x_q <= VW'(mprod_q >>> 30);
          y_q <= num_q;
          z_q <= '0;
        end
        tad_pkg::ST_ROUND: begin
          // zero vector: magnitude and numerator both zero give angle 0
          if (!pass_q) roll_q <= (x_q == '0 && num_q == '0) ? '0 : ang;
          else pitch_q <= (x_q == '0 && num_q == '0) ? '0 : ang;
          pass_q <= 1'b1;
        end
        tad_pkg::ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.roll <= roll_q;
            out_q.pitch <= pitch_q;
            out_q.err <= err;
            out_q.motion <= mot;
            out_q.enable <= ena_q || (mot != tad_pkg::MOTION_HOLD);
            ena_q <= ena_q || (mot != tad_pkg::MOTION_HOLD);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
endmodule

[rtl/core/tilt_angle_deadband_drive.sv]
// Top level of the accelerometer tilt and deadband drive block
//  channel  | dir | handshake          | payload
//  s_axis   | in  | tvalid/tready      | accel_x, accel_y, accel_z
//  m_axis   | out | tvalid/tready      | roll, pitch, error, motion, enable
//  cfg      | in  | cfg_valid/ready    | register index, write data
// An item passes through a pop, the filter update of each axis, four vectoring
// runs of one step a cycle on one shared CORDIC unit (steps capped at 24), setup,
// gain multiply and rounding for each pass, then the output register.
// A two-entry queue takes samples while the back end works; a held output
// register lets the back end finish the next item before m_axis_tready returns.
// Reset restores the register defaults and clears filters and the enable latch.
module tilt_angle_deadband_drive #(
  parameter int unsigned CORDIC_STEPS     = 16,
  parameter int unsigned FILTER_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // roll_angle, pitch_angle, angle_error, motion, drive_enable
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  tad_pkg::sample_t smp, qd;
  tad_pkg::result_t res;
  logic q_valid, q_pop;
  logic signed [16:0] target_q;
  logic [15:0] deadband_q;
  logic [16:0] gain_q;

  assign smp.ax = s_axis_tdata[15:0];
  assign smp.ay = s_axis_tdata[31:16];
  assign smp.az = s_axis_tdata[47:32];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      deadband_q <= 16'd2560;
      gain_q     <= 17'd3277;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tad_pkg::REG_TARGET:   target_q   <= cfg_data_i[16:0];
        tad_pkg::REG_DEADBAND: deadband_q <= cfg_data_i[15:0];
        tad_pkg::REG_GAIN:     gain_q     <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  tad_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(smp),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(qd)
  );

  tad_back #(.CordicSteps(CORDIC_STEPS), .FilterFracBits(FILTER_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(qd),
    .target_i(target_q), .deadband_i(deadband_q), .gain_i(gain_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(res)
  );

  assign m_axis_tdata = {3'b000, res.enable, res.motion, res.err, res.pitch, res.roll};
endmodule

[rtl/core/tad_checker.sv]
// Port-level checker for the tilt drive, bound to the top level
`include "tilt_angle_deadband_drive_macros.svh"
module tad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  `TAD_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
  `TAD_ASSERT(a_motion, m_axis_tvalid |-> m_axis_tdata[51:50] != 2'd3, "invalid motion code")
  `TAD_ASSERT(a_enable, m_axis_tvalid && m_axis_tdata[51:50] != tad_pkg::MOTION_HOLD |-> m_axis_tdata[52], "move without enable")
  `TAD_ASSERT_ALWAYS(a_reset, !rst_ni |=> !m_axis_tvalid, "valid after reset")
endmodule

bind tilt_angle_deadband_drive tad_checker u_tad_checker (.*);

[tb/sv/tilt_angle_deadband_drive_tb.sv]
// Testbench for the tilt angle and deadband drive block
`timescale 1ns / 100ps

module tilt_angle_deadband_drive_tb;

  localparam int unsigned Steps     = 16;
  localparam int unsigned FracBits  = 16;
  localparam int          MaxCycles = 600000;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [17:0] err;
    tad_pkg::motion_e   motion;
    logic               enable;
  } tilt_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  tilt_angle_deadband_drive #(
    .CORDIC_STEPS(Steps),
    .FILTER_FRAC_BITS(FracBits)
  ) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  longint filt_axes[3];
  bit     drive_latch;
  longint target_q;
  longint deadband_q;
  longint gain_q;

  logic [47:0]  pending_samples[$];
  tilt_result_t expected_results[$];
  int  errors;
  int  send_idle_pct, recv_idle_pct;
  bit  recv_hold;
  bit  send_pause;
  int  hold_count;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cordic_angle(longint x, longint y, output longint mag);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < Steps && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y < 0) begin
        x -= dx; y += dy; z -= longint'(tad_pkg::atan_lookup(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(tad_pkg::atan_lookup(5'(i)));
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint tilt_of(longint num, longint a, longint b);
    longint m, mag, z, r;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    void'(cordic_angle(a, b, m));
    mag = floor_shr(m * 64'sd652032874, 30);
    if (mag == 0 && num == 0) return 0;
    z = cordic_angle(mag, num, m);
    r = floor_shr(z + 128, 8);
    if (r > 23040) r = 23040;
    if (r < -23040) r = -23040;
    return r;
  endfunction

  function automatic tilt_result_t predict_tilt(logic [47:0] sample);
    tilt_result_t res;
    longint g, a, w[3], roll, err;
    g = (gain_q > 65536) ? 65536 : gain_q;
    for (int k = 0; k < 3; k++) begin
      a = longint'($signed(sample[16*k +: 16]));
      filt_axes[k] += floor_shr(((a <<< FracBits) - filt_axes[k]) * g, 16);
      w[k] = floor_shr(filt_axes[k], FracBits - tad_pkg::WorkFrac);
    end
    roll = tilt_of(w[1], w[0], w[2]);
    res.roll = 16'(roll);
    res.pitch = 16'(tilt_of(w[0], w[1], w[2]));
    err = target_q - roll;
    res.err = 18'(err);
    if (err < -deadband_q) res.motion = tad_pkg::MOTION_FORWARD;
    else if (err > deadband_q) res.motion = tad_pkg::MOTION_BACKWARD;
    else res.motion = tad_pkg::MOTION_HOLD;
    if (res.motion != tad_pkg::MOTION_HOLD) drive_latch = 1'b1;
    res.enable = drive_latch;
    return res;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(predict_tilt(s_axis_tdata));
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_samples.size() > 0 && !send_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall and long hold-off
  always @(posedge clk_i) begin
    if (recv_hold && hold_count < 400) begin
      hold_count <= hold_count + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tilt_result_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_axis_tdata[15:0] !== exp_r.roll) begin
          $display("%0t: roll exp %0d got %0d", $time, exp_r.roll,
                   $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[31:16] !== exp_r.pitch) begin
          $display("%0t: pitch exp %0d got %0d", $time, exp_r.pitch,
                   $signed(m_axis_tdata[31:16]));
          errors++;
        end
        if (m_axis_tdata[49:32] !== exp_r.err) begin
          $display("%0t: error exp %0d got %0d", $time, exp_r.err,
                   $signed(m_axis_tdata[49:32]));
          errors++;
        end
        if (m_axis_tdata[51:50] !== exp_r.motion) begin
          $display("%0t: motion exp %0d got %0d", $time, exp_r.motion,
                   m_axis_tdata[51:50]);
          errors++;
        end
        if (m_axis_tdata[52] !== exp_r.enable) begin
          $display("%0t: enable exp %0b got %0b", $time, exp_r.enable,
                   m_axis_tdata[52]);
          errors++;
        end
        if (m_axis_tdata[55:53] !== 3'b000) begin
          $display("%0t: pad exp 0 got %0b", $time, m_axis_tdata[55:53]);
          errors++;
        end
      end
    end
  end

  // cycle limit
  initial begin
    repeat (MaxCycles) @(posedge clk_i);
    $display("[tilt_angle_deadband_drive] ERROR");
    $finish;
  end

  task automatic write_reg(tad_pkg::reg_idx_e idx, logic [31:0] value);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      tad_pkg::REG_TARGET:   target_q = longint'($signed(value[16:0]));
      tad_pkg::REG_DEADBAND: deadband_q = longint'(value[15:0]);
      tad_pkg::REG_GAIN:     gain_q = longint'(value[16:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (pending_samples.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_sample();
    logic [15:0] base;
    // mostly near a tilted gravity vector, sometimes full-range noise
    if ($urandom_range(3) == 0) return {16'($urandom), 16'($urandom), 16'($urandom)};
    base = 16'($urandom_range(16384));
    return {16'(base + $urandom_range(2000)), 16'($signed(16'($urandom_range(16000))) - 8000),
            16'($signed(16'($urandom_range(16000))) - 8000)};
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) pending_samples.push_back(rand_sample());
    drain_results();
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    send_pause = 1'b0;
    hold_count = 0;
    filt_axes = '{0, 0, 0};
    drive_latch = 1'b0;
    target_q = 0;
    deadband_q = 2560;
    gain_q = 3277;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: zero vector, extremes, full gain
    pending_samples.push_back('0);
    pending_samples.push_back({16'h7fff, 16'h7fff, 16'h7fff});
    pending_samples.push_back({16'h8000, 16'h8000, 16'h8000});
    drain_results();
    write_reg(tad_pkg::REG_GAIN, 32'd65536);
    write_reg(tad_pkg::REG_DEADBAND, 32'd0);
    write_reg(tad_pkg::REG_TARGET, 32'h1_0000);
    pending_samples.push_back({16'h7fff, 16'h0000, 16'h0000});
    pending_samples.push_back({16'h8000, 16'h0000, 16'h0000});
    pending_samples.push_back({16'h0000, 16'h7fff, 16'h0000});
    pending_samples.push_back({16'h0000, 16'h8000, 16'h0000});
    pending_samples.push_back({16'h0000, 16'h0000, 16'h7fff});
    pending_samples.push_back({16'h0000, 16'h0000, 16'h8000});
    pending_samples.push_back('0);
    pending_samples.push_back({16'hffff, 16'hffff, 16'hffff});
    pending_samples.push_back({16'h4000, 16'h0000, 16'h4000});
    pending_samples.push_back({16'h4000, 16'hc000, 16'h4000});
    drain_results();
    write_reg(tad_pkg::REG_GAIN, 32'h1_ffff);  // gain above one saturates
    write_reg(tad_pkg::REG_TARGET, 32'h0_ffff);
    write_reg(tad_pkg::REG_DEADBAND, 32'hffff);
    pending_samples.push_back({16'h1234, 16'h8765, 16'h5555});
    pending_samples.push_back({16'haaaa, 16'h5555, 16'h0001});
    drain_results();
    write_reg(tad_pkg::REG_GAIN, 32'd0);
    pending_samples.push_back({16'h7fff, 16'h8000, 16'h7fff});
    drain_results();

    // random: sender idles little, receiver a lot; one long receiver hold-off
    write_reg(tad_pkg::REG_GAIN, 32'd3277);
    write_reg(tad_pkg::REG_DEADBAND, 32'd2560);
    write_reg(tad_pkg::REG_TARGET, 32'd0);
    send_idle_pct = 13;
    recv_idle_pct = 67;
    recv_hold = 1'b1;
    random_phase(300);
    recv_hold = 1'b0;
    write_reg(tad_pkg::REG_TARGET, 32'(-46080));
    write_reg(tad_pkg::REG_DEADBAND, 32'd46080);
    random_phase(250);

    send_idle_pct = 67;
    recv_idle_pct = 13;
    write_reg(tad_pkg::REG_TARGET, 32'd46080);
    write_reg(tad_pkg::REG_DEADBAND, 32'd100);
    write_reg(tad_pkg::REG_GAIN, 32'd20000);
    random_phase(250);
    write_reg(tad_pkg::REG_TARGET, 32'($signed(17'($urandom))));
    write_reg(tad_pkg::REG_GAIN, 32'd65536);
    random_phase(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(tad_pkg::REG_TARGET, 32'd1000);
    write_reg(tad_pkg::REG_DEADBAND, 32'd0);
    write_reg(tad_pkg::REG_GAIN, 32'($urandom_range(65536)));
    random_phase(300);
    write_reg(tad_pkg::REG_DEADBAND, 32'($urandom_range(65535)));
    write_reg(tad_pkg::REG_GAIN, 32'($urandom_range(131071)));
    random_phase(300);

    drain_results();
    if (errors == 0) begin
      $display("[tilt_angle_deadband_drive] OK");
    end else begin
      $display("[tilt_angle_deadband_drive] ERROR");
    end
    $finish;
  end

endmodule
